// ----- rtl/ok2rgb_pkg.sv -----
// shared constants for the oklch to linear rgb converter
`default_nettype none

package ok2rgb_pkg;

  localparam int FRAC_BITS_DEF  = 15;
  localparam int ANGLE_BITS_DEF = 16;

  // internal fixed-point fraction bits
  localparam int IW = 24;

  // cordic rotation count and datapath width
  localparam int CORDIC_STEPS = 24;
  localparam int XW           = 33;

  // matrix coefficient width, signed q.24
  localparam int KW = 28;

  localparam longint Q_ONE  = 64'sd1 <<< IW;
  localparam longint Q_DEN  = 64'sd10000000000;
  localparam longint Q_HALF = 64'sd5000000000;

  // lab to lms' rows: l (a, b), m (a, b), s (a, b), magnitudes only
  localparam longint KA [6] = '{
    (64'sd3963377774  * Q_ONE + Q_HALF) / Q_DEN,
    (64'sd2158037573  * Q_ONE + Q_HALF) / Q_DEN,
    (64'sd1055613458  * Q_ONE + Q_HALF) / Q_DEN,
    (64'sd638541728   * Q_ONE + Q_HALF) / Q_DEN,
    (64'sd894841775   * Q_ONE + Q_HALF) / Q_DEN,
    (64'sd12914855480 * Q_ONE + Q_HALF) / Q_DEN
  };

  // lms to rgb, row major, signs applied after rounding
  localparam longint KB [9] = '{
     ((64'sd40767416621 * Q_ONE + Q_HALF) / Q_DEN),
    -((64'sd33077115913 * Q_ONE + Q_HALF) / Q_DEN),
     ((64'sd2309699292  * Q_ONE + Q_HALF) / Q_DEN),
    -((64'sd12684380046 * Q_ONE + Q_HALF) / Q_DEN),
     ((64'sd26097574011 * Q_ONE + Q_HALF) / Q_DEN),
    -((64'sd3413193965  * Q_ONE + Q_HALF) / Q_DEN),
    -((64'sd41960863    * Q_ONE + Q_HALF) / Q_DEN),
    -((64'sd7034186147  * Q_ONE + Q_HALF) / Q_DEN),
     ((64'sd17076147010 * Q_ONE + Q_HALF) / Q_DEN)
  };

  // cordic start vector, q.30
  localparam logic signed [XW-1:0] CORDIC_GAIN =
    XW'((64'sd6072529350 * 64'sd1073741824 + Q_HALF) / Q_DEN);

  // arctangent of 2^-i as a 32-bit fraction of a turn
  localparam logic signed [XW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

endpackage

`default_nettype wire

// ----- rtl/oklch_to_linear_rgb.sv -----
// oklch to linear rgb converter, fully pipelined fixed-point datapath
//
//  channel | ports             | payload
//  --------+-------------------+---------------------------------------------
//  input   | in_tvalid/tready  | lightness q1.15, chroma q1.15, hue 16-bit turn
//  output  | out_tvalid/tready | red, green, blue, linear q1.15, clamped 0..1
//
// one colour request accepted every clock while the skid register is empty; the
// pipeline is an input stage, twelve cordic stages of two rotations each,
// eleven multiply, round and sum stages after them and the output register
// synchronous active-low reset clears only the valid bits and the output flags
// the pipeline advances as one; a skid register catches the result that leaves
// while the output register waits on out_tready, and in_tready drops only once it is full
`default_nettype none

module oklch_to_linear_rgb
  import ok2rgb_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // lightness [15:0], chroma [31:16], hue_angle [47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // red [15:0], green [31:16], blue [47:32]
);

  // pipeline shape
  localparam int NCS     = CORDIC_STEPS / 2;  // two rotations per stage
  localparam int LW_LAST = NCS + 4;           // lightness is used in the lms' stage
  localparam int NPIPE   = NCS + 12;

  // datapath widths
  localparam int LWW  = 16 + IW - FRAC_BITS;
  localparam int LW_SH = IW - FRAC_BITS;
  localparam int CPW  = 17 + XW;
  localparam int SH_A = FRAC_BITS + 30 - IW;
  localparam int AW   = 18 + IW - FRAC_BITS;
  localparam int KPW  = KW + AW;
  localparam int MPW  = KPW + 1;
  localparam int TW   = MPW - IW;
  localparam int PRW  = TW + 1;
  localparam int VW   = IW + 5;
  localparam int SQW  = 2 * VW;
  localparam int SQ2W = SQW - IW;
  localparam int CUW  = SQ2W + VW;
  localparam int CBW  = IW + 11;
  localparam int OPW  = KW + CBW;
  localparam int OSW  = OPW + 2;
  localparam int SH_O = 2 * IW - FRAC_BITS;
  localparam int RW   = OSW - SH_O;
  localparam int OUT_MAX = (FRAC_BITS >= 16) ? 65535 : (1 << FRAC_BITS);
  localparam int PH_SH   = 32 - ANGLE_BITS;

  localparam logic [15:0] HUE_MASK = 16'((32'd1 << ANGLE_BITS) - 32'd1);

  // rounding offsets and limits
  localparam logic signed [CPW-1:0] HALF_A = CPW'(64'sd1 <<< (SH_A - 1));
  localparam logic signed [MPW-1:0] HALF_M = MPW'(64'sd1 <<< (IW - 1));
  localparam logic signed [SQW-1:0] HALF_S = SQW'(64'sd1 <<< (IW - 1));
  localparam logic signed [CUW-1:0] HALF_C = CUW'(64'sd1 <<< (IW - 1));
  localparam logic signed [OSW-1:0] HALF_O = OSW'(64'sd1 <<< (SH_O - 1));
  localparam logic signed [PRW-1:0] PRIME_LIM   = PRW'(64'sd1 <<< (IW + 3));
  localparam logic signed [VW-1:0]  PRIME_LIM_V = VW'(64'sd1 <<< (IW + 3));
  localparam logic signed [RW-1:0]  OUT_MAX_R   = RW'(OUT_MAX);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
  } cd_t;

  // one cordic rotation towards zero residual angle
  function automatic cd_t cd_step(input cd_t a, input int unsigned i);
    cd_t r;
    if (!a.z[XW-1]) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - ATAN_TURNS[i];
    end else begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + ATAN_TURNS[i];
    end
    return r;
  endfunction

  // saturate l', m', s' to plus or minus eight
  function automatic logic signed [VW-1:0] clamp_prime(input logic signed [PRW-1:0] v);
    if (v > PRIME_LIM) begin
      return PRIME_LIM_V;
    end else if (v < -PRIME_LIM) begin
      return -PRIME_LIM_V;
    end
    return VW'(v);
  endfunction

  // round the rgb sum down to the output format and clamp
  function automatic logic [15:0] to_channel(input logic signed [OSW-1:0] s);
    logic signed [RW-1:0] v;
    v = RW'((s + HALF_O) >>> SH_O);
    if (v < 0) begin
      return 16'd0;
    end else if (v > OUT_MAX_R) begin
      return 16'(OUT_MAX);
    end
    return v[15:0];
  endfunction

  // stage control
  logic              adv;
  logic [NPIPE-1:0]  vld_r;
  logic              ovld_r;
  logic              skid_vld_r;
  logic [47:0]       odata_r;
  logic [47:0]       sdata_r;
  logic              out_take;
  logic              pipe_emit;

  // input stage logic: phase fold into the right half-plane
  logic [15:0]       hue_m;
  logic [31:0]       ph;
  logic [31:0]       ph_f;
  logic              flip;
  logic [LWW-1:0]    lw_nxt;

  // stage registers
  cd_t                    cd_r   [NCS+1];
  cd_t                    cd_nxt [NCS+1];
  logic [LWW-1:0]         lw_r   [LW_LAST+1];
  logic [15:0]            cv_r   [NCS+1];
  logic                   flip_r [NCS+1];
  logic signed [XW-1:0]   cs_v;
  logic signed [XW-1:0]   sn_v;
  logic signed [16:0]     cv_s;
  logic signed [CPW-1:0]  ca_r;
  logic signed [CPW-1:0]  sb_r;
  logic signed [AW-1:0]   aw_r;
  logic signed [AW-1:0]   bw_r;
  logic signed [KPW-1:0]  pk_r   [6];
  logic signed [TW-1:0]   t_r    [3];
  logic signed [PRW-1:0]  lwe;
  logic signed [VW-1:0]   pr_nxt [3];
  logic signed [VW-1:0]   pr_r   [3];
  logic signed [VW-1:0]   pv1_r  [3];
  logic signed [VW-1:0]   pv2_r  [3];
  logic signed [SQW-1:0]  sq_r   [3];
  logic signed [SQ2W-1:0] sqr_r  [3];
  logic signed [CUW-1:0]  cu_r   [3];
  logic signed [CBW-1:0]  cb_r   [3];
  logic signed [OPW-1:0]  op_r   [9];
  logic signed [OSW-1:0]  os_r   [3];
  logic [47:0]            res;

  assign adv       = !skid_vld_r;
  assign in_tready = adv;
  assign out_take  = ovld_r && out_tready;
  assign pipe_emit = adv && vld_r[NPIPE-1];

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  // a phase in the left half-plane is moved by half a turn and negated later
  assign hue_m  = in_tdata[47:32] & HUE_MASK;
  assign ph     = 32'(hue_m) << PH_SH;
  assign flip   = ph[31] ^ ph[30];
  assign ph_f   = {ph[31] ^ flip, ph[30:0]};
  assign lw_nxt = LWW'(in_tdata[15:0]) << LW_SH;

  assign cd_nxt[0] = '{x: CORDIC_GAIN, y: '0, z: XW'(signed'(ph_f))};

  // cordic stages, two rotations each
  for (genvar g = 0; g < NCS; g++) begin : g_cordic
    assign cd_nxt[g+1] = cd_step(cd_step(cd_r[g], 2 * g), 2 * g + 1);
  end

  // undo the half-turn fold on cos and sin
  assign cs_v = flip_r[NCS] ? -cd_r[NCS].x : cd_r[NCS].x;
  assign sn_v = flip_r[NCS] ? -cd_r[NCS].y : cd_r[NCS].y;
  assign cv_s = signed'({1'b0, cv_r[NCS]});

  // l', m', s' from lightness and the rounded matrix terms
  assign lwe       = PRW'(signed'({1'b0, lw_r[LW_LAST]}));
  assign pr_nxt[0] = clamp_prime(lwe + PRW'(t_r[0]));
  assign pr_nxt[1] = clamp_prime(lwe - PRW'(t_r[1]));
  assign pr_nxt[2] = clamp_prime(lwe - PRW'(t_r[2]));

  assign res = {to_channel(os_r[2]), to_channel(os_r[1]), to_channel(os_r[0])};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NPIPE-2:0], in_tvalid};
    end
  end

  // datapath, all stages move together
  always_ff @(posedge clk) begin
    if (adv) begin
      // input stage
      cd_r[0]   <= cd_nxt[0];
      lw_r[0]   <= lw_nxt;
      cv_r[0]   <= in_tdata[31:16];
      flip_r[0] <= flip;
      // cordic stages
      for (int k = 1; k <= NCS; k++) begin
        cd_r[k]   <= cd_nxt[k];
        cv_r[k]   <= cv_r[k-1];
        flip_r[k] <= flip_r[k-1];
      end
      for (int k = 1; k <= LW_LAST; k++) begin
        lw_r[k] <= lw_r[k-1];
      end
      // chroma times cos and sin
      ca_r <= CPW'(cv_s * cs_v);
      sb_r <= CPW'(cv_s * sn_v);
      // a and b in q.24
      aw_r <= AW'((ca_r + HALF_A) >>> SH_A);
      bw_r <= AW'((sb_r + HALF_A) >>> SH_A);
      // first matrix products
      for (int k = 0; k < 3; k++) begin
        pk_r[2*k]   <= KPW'(KW'(KA[2*k]) * aw_r);
        pk_r[2*k+1] <= KPW'(KW'(KA[2*k+1]) * bw_r);
      end
      // row sums rounded to q.24
      for (int k = 0; k < 3; k++) begin
        t_r[k] <= TW'((MPW'(pk_r[2*k]) + MPW'(pk_r[2*k+1]) + HALF_M) >>> IW);
      end
      // saturated l', m', s'
      for (int k = 0; k < 3; k++) begin
        pr_r[k] <= pr_nxt[k];
      end
      // cube: square, round, multiply, round
      for (int k = 0; k < 3; k++) begin
        sq_r[k]  <= SQW'(pr_r[k] * pr_r[k]);
        pv1_r[k] <= pr_r[k];
        sqr_r[k] <= SQ2W'((sq_r[k] + HALF_S) >>> IW);
        pv2_r[k] <= pv1_r[k];
        cu_r[k]  <= CUW'(sqr_r[k] * pv2_r[k]);
        cb_r[k]  <= CBW'((cu_r[k] + HALF_C) >>> IW);
      end
      // second matrix products and row sums
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          op_r[3*r+c] <= OPW'(KW'(KB[3*r+c]) * cb_r[c]);
        end
        os_r[r] <= OSW'(op_r[3*r]) + OSW'(op_r[3*r+1]) + OSW'(op_r[3*r+2]);
      end
    end
  end

  // output register and skid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r     <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (pipe_emit) begin
      if (ovld_r && !out_take) begin
        skid_vld_r <= 1'b1;
      end else begin
        ovld_r <= 1'b1;
      end
    end else if (out_take) begin
      ovld_r <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        odata_r <= sdata_r;
      end
    end else if (pipe_emit) begin
      if (ovld_r && !out_take) begin
        sdata_r <= res;
      end else begin
        odata_r <= res;
      end
    end
  end

  // skid holds a request only behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> ovld_r)
    else $error("skid register full while output register empty");

  // a full skid freezes the pipeline
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |=> $stable(vld_r))
    else $error("pipeline moved while skid register full");

  // a result leaving the pipeline is never dropped
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_emit |=> ovld_r)
    else $error("result left the pipeline but no output is valid");

  // channels stay within zero through one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> (odata_r[15:0] <= 16'(OUT_MAX)) && (odata_r[31:16] <= 16'(OUT_MAX))
               && (odata_r[47:32] <= 16'(OUT_MAX)))
    else $error("output channel above one");

endmodule

`default_nettype wire
